@@ rtl/gaussian_downsample_by_three_core_macros.svh @@
// Assertion macros for the Gaussian downsample-by-three core.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef GAUSSIAN_DOWNSAMPLE_BY_THREE_CORE_MACROS_SVH
`define GAUSSIAN_DOWNSAMPLE_BY_THREE_CORE_MACROS_SVH

// consequent checked in the same cycle
`define GDS3_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define GDS3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gds3_pkg.sv @@
// Shared types, codes and constants of the Gaussian downsample-by-three core.
// No dependencies.
`default_nettype none

package gds3_pkg;

  localparam int CHANNEL_BITS      = 16;
  localparam int SUM_W             = CHANNEL_BITS + 4;
  localparam int NCH               = 7;
  localparam int MAX_OUT_WIDTH_DEF = 1024;
  localparam int DOWN_FACTOR       = 3;
  localparam int COL_W             = 10;
  localparam int ROW_W             = 12;
  localparam int IN_ROW_W          = 14;
  localparam int MODE_W            = 2;
  localparam int OUT_WIDTH_W       = 11;
  localparam int OUT_HEIGHT_W      = 13;
  localparam int OUT_HEIGHT_MAX    = 4096;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 13;
  localparam int QUEUE_DEPTH       = 4;
  localparam int ROUND_BIAS        = 8;
  localparam int KERNEL_SHIFT      = 4;
  localparam int PHASE_W           = 2;

  localparam logic [MODE_W-1:0] MODE_PASS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GAUSS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 2'd2;

  localparam logic [OUT_WIDTH_W-1:0]  OUT_WIDTH_RST  = 11'd1024;
  localparam logic [OUT_HEIGHT_W-1:0] OUT_HEIGHT_RST = 13'd768;

  // position of an input pixel inside its group of three
  localparam logic [PHASE_W-1:0] PH_CENTER = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RIGHT  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LEFT   = 2'd2;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_STORE,
    OP_ACCUM,
    OP_FINAL
  } op_kind_t;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [SUM_W-1:0]        sum_t;

  typedef struct packed {
    chan_t color_red;
    chan_t color_green;
    chan_t color_blue;
    chan_t normal_x;
    chan_t normal_y;
    chan_t normal_z;
    chan_t depth_value;
  } pixel_in_t;

  typedef struct packed {
    chan_t              out_red;
    chan_t              out_green;
    chan_t              out_blue;
    chan_t              out_normal_x;
    chan_t              out_normal_y;
    chan_t              out_normal_z;
    chan_t              out_depth;
    logic [COL_W-1:0]   out_col;
    logic [ROW_W-1:0]   out_row;
    logic               frame_end;
  } pixel_out_t;

  // one queued operation for the back end
  typedef struct packed {
    op_kind_t           kind;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               last;
    sum_t [NCH-1:0]     sums;
  } op_t;

endpackage

`default_nettype wire

@@ rtl/gds3_front.sv @@
// Front end: input position counters, classification and horizontal 1-2-1 sums.
// Depends on gds3_pkg.
`default_nettype none

module gds3_front #(
  parameter int MAX_OUT_WIDTH = gds3_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  gds3_pkg::pixel_in_t                 pix,
  input  logic [gds3_pkg::MODE_W-1:0]         filter_mode,
  input  logic [gds3_pkg::OUT_WIDTH_W-1:0]    out_width,
  input  logic [gds3_pkg::OUT_HEIGHT_W-1:0]   out_height,
  output gds3_pkg::op_t                       op,
  output logic                                op_valid,
  output logic [$clog2(MAX_OUT_WIDTH)-1:0]    op_addr
);
  import gds3_pkg::*;

  localparam int AW    = $clog2(MAX_OUT_WIDTH);
  localparam int WW    = $clog2(MAX_OUT_WIDTH + 1);
  localparam int CW    = $clog2(DOWN_FACTOR * MAX_OUT_WIDTH + 1);
  localparam int CW1   = CW + 1;
  localparam int RW1   = IN_ROW_W + 1;
  localparam int EXT_W = (WW > OUT_WIDTH_W) ? WW : OUT_WIDTH_W;

  logic [CW-1:0]         c_r, c_nxt;
  logic [IN_ROW_W-1:0]   r_r, r_nxt;
  logic [AW-1:0]         x_r, x_nxt;
  logic [ROW_W-1:0]      y_r, y_nxt;
  logic [PHASE_W-1:0]    cp_r, cp_nxt, rp_r, rp_nxt;
  sum_t [NCH-1:0]        hs_r, hs_nxt;
  sum_t [NCH-1:0]        px, hs2, hs3;

  logic [EXT_W-1:0]        ow_ext;
  logic [WW-1:0]           w_eff;
  logic [OUT_HEIGHT_W-1:0] h_eff;
  logic [CW-1:0]           in_w;
  logic [IN_ROW_W-1:0]     in_h;
  logic                    down, gauss, point;
  logic                    col_wrap, row_wrap, x_in, y_in, x_last, y_last;

  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph);
    logic [PHASE_W-1:0] res;
    case (ph)
      PH_CENTER: res = PH_RIGHT;
      PH_RIGHT:  res = PH_LEFT;
      default:   res = PH_CENTER;
    endcase
    return res;
  endfunction

  always_comb begin
    px[0] = SUM_W'(pix.color_red);
    px[1] = SUM_W'(pix.color_green);
    px[2] = SUM_W'(pix.color_blue);
    px[3] = SUM_W'(pix.normal_x);
    px[4] = SUM_W'(pix.normal_y);
    px[5] = SUM_W'(pix.normal_z);
    px[6] = SUM_W'(pix.depth_value);
  end

  // effective sizes
  always_comb begin
    ow_ext = EXT_W'(out_width);
    if (out_width == '0) begin
      w_eff = WW'(1);
    end else if (ow_ext > EXT_W'(MAX_OUT_WIDTH)) begin
      w_eff = WW'(MAX_OUT_WIDTH);
    end else begin
      w_eff = WW'(out_width);
    end
    if (out_height == '0) begin
      h_eff = OUT_HEIGHT_W'(1);
    end else if (out_height > OUT_HEIGHT_W'(OUT_HEIGHT_MAX)) begin
      h_eff = OUT_HEIGHT_W'(OUT_HEIGHT_MAX);
    end else begin
      h_eff = out_height;
    end
  end

  assign down  = filter_mode inside {MODE_POINT, MODE_GAUSS};
  assign gauss = (filter_mode == MODE_GAUSS);
  assign point = (filter_mode == MODE_POINT);

  assign in_w = down ? CW'(w_eff) * CW'(DOWN_FACTOR) : CW'(w_eff);
  assign in_h = down ? IN_ROW_W'(h_eff) * IN_ROW_W'(DOWN_FACTOR) : IN_ROW_W'(h_eff);

  assign col_wrap = ({1'b0, c_r} + CW1'(1)) >= {1'b0, in_w};
  assign row_wrap = ({1'b0, r_r} + RW1'(1)) >= {1'b0, in_h};
  assign x_in     = WW'(x_r) < w_eff;
  assign y_in     = OUT_HEIGHT_W'(y_r) < h_eff;
  assign x_last   = (WW'(x_r) + WW'(1)) == w_eff;
  assign y_last   = (OUT_HEIGHT_W'(y_r) + OUT_HEIGHT_W'(1)) == h_eff;

  // position counters
  always_comb begin
    c_nxt  = c_r + CW'(1);
    cp_nxt = next_phase(cp_r);
    x_nxt  = (cp_r == PH_LEFT) ? x_r + AW'(1) : x_r;
    r_nxt  = r_r;
    rp_nxt = rp_r;
    y_nxt  = y_r;
    if (col_wrap) begin
      c_nxt  = '0;
      cp_nxt = PH_CENTER;
      x_nxt  = '0;
      if (row_wrap) begin
        r_nxt  = '0;
        rp_nxt = PH_CENTER;
        y_nxt  = '0;
      end else begin
        r_nxt  = r_r + IN_ROW_W'(1);
        rp_nxt = next_phase(rp_r);
        y_nxt  = (rp_r == PH_LEFT) ? y_r + ROW_W'(1) : y_r;
      end
    end
  end

  // horizontal 1-2-1, column -1 clamped to column 0
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      case (cp_r)
        PH_LEFT:   hs_nxt[k] = px[k];
        PH_CENTER: hs_nxt[k] = (c_r == '0) ? px[k] + (px[k] << 1) : hs_r[k] + (px[k] << 1);
        default:   hs_nxt[k] = hs_r[k] + px[k];
      endcase
      hs2[k] = hs_nxt[k] << 1;
      hs3[k] = hs_nxt[k] + (hs_nxt[k] << 1);
    end
  end

  // classification
  always_comb begin
    op       = '0;
    op.kind  = OP_EMIT;
    op.sums  = px;
    op.col   = COL_W'(x_r);
    op.row   = y_r;
    op.last  = x_last && y_last;
    op_valid = 1'b0;
    op_addr  = x_r;
    if (!down) begin
      op.col   = COL_W'(c_r);
      op.row   = ROW_W'(r_r);
      op.last  = col_wrap && row_wrap;
      op_valid = 1'b1;
    end else if (point) begin
      op_valid = (cp_r == PH_RIGHT) && (rp_r == PH_RIGHT) && x_in && y_in;
    end else if (gauss && (cp_r == PH_RIGHT) && x_in) begin
      case (rp_r)
        PH_LEFT: begin
          op.kind  = OP_STORE;
          op.sums  = hs_nxt;
          op_valid = 1'b1;
        end
        PH_CENTER: begin
          op.kind  = (r_r == '0) ? OP_STORE : OP_ACCUM;
          op.sums  = (r_r == '0) ? hs3 : hs2;
          op_valid = 1'b1;
        end
        PH_RIGHT: begin
          op.kind  = OP_FINAL;
          op.sums  = hs_nxt;
          op_valid = y_in;
        end
        default: begin
          op_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r  <= '0;
      r_r  <= '0;
      x_r  <= '0;
      y_r  <= '0;
      cp_r <= PH_CENTER;
      rp_r <= PH_CENTER;
      hs_r <= '0;
    end else if (accept) begin
      c_r  <= c_nxt;
      r_r  <= r_nxt;
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      cp_r <= cp_nxt;
      rp_r <= rp_nxt;
      if (gauss) begin
        hs_r <= hs_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/gds3_queue.sv @@
// Short operation queue between the front end and the back end.
// Depends on gds3_pkg.
`default_nettype none

module gds3_queue #(
  parameter int MAX_OUT_WIDTH = gds3_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  gds3_pkg::op_t                     push_op,
  input  logic [$clog2(MAX_OUT_WIDTH)-1:0]  push_addr,
  output logic                              full,
  input  logic                              pop,
  output logic                              not_empty,
  output gds3_pkg::op_t                     head_op,
  output logic [$clog2(MAX_OUT_WIDTH)-1:0]  head_addr
);
  import gds3_pkg::*;

  localparam int AW   = $clog2(MAX_OUT_WIDTH);
  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  op_t             ops_r  [QUEUE_DEPTH];
  logic [AW-1:0]   addr_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;

  assign full      = (count_r == CNTW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = ops_r[rd_ptr_r];
  assign head_addr = addr_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ops_r[wr_ptr_r]  <= push_op;
      addr_r[wr_ptr_r] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNTW'(1);
        2'b01:   count_r <= count_r - CNTW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/gds3_back.sv @@
// Back end: column-sum line store read-modify-write, rounding and output register.
// Depends on gds3_pkg.
`default_nettype none

module gds3_back #(
  parameter int MAX_OUT_WIDTH = gds3_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  gds3_pkg::op_t                     q_op,
  input  logic [$clog2(MAX_OUT_WIDTH)-1:0]  q_addr,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gds3_pkg::pixel_out_t              out_data
);
  import gds3_pkg::*;

  localparam int AW = $clog2(MAX_OUT_WIDTH);

  sum_t [NCH-1:0]  line_mem_r [MAX_OUT_WIDTH];
  sum_t [NCH-1:0]  rdata_r, fwd_data_r, col_sum, wr_data;
  chan_t [NCH-1:0] res;
  logic [SUM_W:0]  fin_sum;
  logic            fwd_r;
  op_t             cur_r;
  logic [AW-1:0]   cur_addr_r;
  logic            cur_valid_r;
  logic            cur_writes, cur_emits, out_free, fire;
  logic            out_valid_r;
  pixel_out_t      out_data_r, out_nxt;

  assign cur_writes = cur_r.kind inside {OP_STORE, OP_ACCUM};
  assign cur_emits  = cur_r.kind inside {OP_EMIT, OP_FINAL};
  assign out_free   = !out_valid_r || out_ready;
  assign fire       = cur_valid_r && (!cur_emits || out_free);
  assign pop        = q_valid && (!cur_valid_r || fire);
  assign col_sum    = fwd_r ? fwd_data_r : rdata_r;

  // vertical 1-2-1 and (sum + 8) >> 4
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      wr_data[k] = (cur_r.kind == OP_STORE) ? cur_r.sums[k] : col_sum[k] + cur_r.sums[k];
      fin_sum = (SUM_W + 1)'(col_sum[k]) + (SUM_W + 1)'(cur_r.sums[k])
              + (SUM_W + 1)'(ROUND_BIAS);
      res[k] = (cur_r.kind == OP_EMIT) ? cur_r.sums[k][CHANNEL_BITS-1:0]
                                      : fin_sum[KERNEL_SHIFT +: CHANNEL_BITS];
    end
  end

  always_comb begin
    out_nxt.out_red      = res[0];
    out_nxt.out_green    = res[1];
    out_nxt.out_blue     = res[2];
    out_nxt.out_normal_x = res[3];
    out_nxt.out_normal_y = res[4];
    out_nxt.out_normal_z = res[5];
    out_nxt.out_depth    = res[6];
    out_nxt.out_col      = cur_r.col;
    out_nxt.out_row      = cur_r.row;
    out_nxt.frame_end    = cur_r.last;
  end

  always_ff @(posedge clk) begin
    if (fire && cur_writes) begin
      line_mem_r[cur_addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata_r <= line_mem_r[q_addr];
    end
  end

  // same-column write in flight bypasses the stale read
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= q_op;
      cur_addr_r <= q_addr;
      fwd_data_r <= wr_data;
    end
    if (fire && cur_emits) begin
      out_data_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
        fwd_r       <= fire && cur_writes && (cur_addr_r == q_addr);
      end else if (fire) begin
        cur_valid_r <= 1'b0;
      end
      if (fire && cur_emits) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ rtl/gaussian_downsample_by_three_core.sv @@
// Top level of the Gaussian downsample-by-three core: configuration registers,
// front end, operation queue and back end. Depends on gds3_pkg and the gds3_* modules.
//
// Takes one supersampled pixel per clock in raster order and sustains that rate
// while the output is not stalled: each input transaction yields at most one queued
// operation, and the back end retires one operation per clock through one read and
// at most one write of the column-sum line store, which sets the one-pixel-per-clock
// figure. A result passes the queue, the current-operation register and the output
// register on its way to out_data. filter_mode selects pass-through (0 or 3), point
// sampling of pixel (3x+1, 3y+1) (1) or the 1-2-1 by 1-2-1 kernel centered on
// (3x, 3y), edges clamped, rounded (sum + 8) >> 4 (2). The line store holds
// MAX_OUT_WIDTH entries of seven 20-bit column sums; it has no reset and needs no
// clearing pass. Write the registers only while the core is idle.
`default_nettype none

module gaussian_downsample_by_three_core #(
  parameter int MAX_OUT_WIDTH = gds3_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  gds3_pkg::pixel_in_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output gds3_pkg::pixel_out_t               out_data,
  input  logic                               cfg_we,
  input  logic [gds3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gds3_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import gds3_pkg::*;

  localparam int AW = $clog2(MAX_OUT_WIDTH);

  logic [MODE_W-1:0]       filter_mode_r;
  logic [OUT_WIDTH_W-1:0]  out_width_r;
  logic [OUT_HEIGHT_W-1:0] out_height_r;

  logic          accept, op_valid, q_full, q_not_empty, q_pop;
  op_t           op, head_op;
  logic [AW-1:0] op_addr, head_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r <= MODE_PASS;
      out_width_r   <= OUT_WIDTH_RST;
      out_height_r  <= OUT_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_MODE: filter_mode_r <= cfg_wdata[MODE_W-1:0];
        CFG_OUT_WIDTH:   out_width_r   <= cfg_wdata[OUT_WIDTH_W-1:0];
        CFG_OUT_HEIGHT:  out_height_r  <= cfg_wdata[OUT_HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  gds3_front #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pix         (in_data),
    .filter_mode (filter_mode_r),
    .out_width   (out_width_r),
    .out_height  (out_height_r),
    .op          (op),
    .op_valid    (op_valid),
    .op_addr     (op_addr)
  );

  gds3_queue #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && op_valid),
    .push_op   (op),
    .push_addr (op_addr),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op),
    .head_addr (head_addr)
  );

  gds3_back #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_op      (head_op),
    .q_addr    (head_addr),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/gds3_checker.sv @@
// Port-level checks for the Gaussian downsample-by-three core, bound to the top level.
// Depends on gds3_pkg and gaussian_downsample_by_three_core_macros.svh.
`default_nettype none
`include "gaussian_downsample_by_three_core_macros.svh"

module gds3_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  gds3_pkg::pixel_out_t out_data
);

  `GDS3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed or dropped")

  `GDS3_ASSERT_SAME(a_reset_idle, $past(!rst_n), !out_valid && in_ready, "core not idle after reset")

  // the queue only fills up behind a stalled output
  `GDS3_ASSERT_SAME(a_full_cause, !in_ready && in_valid, $past(!in_ready) || $past(out_valid && !out_ready), "input stalled without output backpressure")

endmodule

bind gaussian_downsample_by_three_core gds3_checker u_gds3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_downsample_by_three_core: random and directed pixel
// streams under random stalls, with results checked against an in-bench predictor.
// Depends on gds3_pkg and the core RTL.

module tb_top;
  import gds3_pkg::*;

  localparam int MAX_WAIT     = 11;
  localparam int IDLE_TAIL    = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 550;
  localparam int MAX_REPORTS  = 10;
  localparam int RUN_LIMIT_NS = 20_000_000;

  localparam logic [MODE_W-1:0]    MODE_ALIAS      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  typedef logic [NCH-1:0][CHANNEL_BITS-1:0] chan_vec_t;
  typedef logic [NCH-1:0][SUM_W-1:0]        sum_vec_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  pixel_in_t             in_data;
  logic                  out_valid;
  logic                  out_ready;
  pixel_out_t            out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [MODE_W-1:0] mode_q   = MODE_PASS;
  int unsigned       width_q  = 1024;
  int unsigned       height_q = 768;
  int unsigned       col_pos  = 0;
  int unsigned       row_pos  = 0;
  sum_vec_t          hsum     = '0;
  sum_vec_t          vsum [MAX_OUT_WIDTH_DEF];
  pixel_out_t        expected_pixels [$];

  int unsigned sent_count     = 0;
  int          mismatch_count = 0;
  int          hold_request   = 0;
  bit          in_burst       = 1'b0;
  bit          out_burst      = 1'b0;

  gaussian_downsample_by_three_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic bit is_downsampling();
    return (mode_q == MODE_POINT) || (mode_q == MODE_GAUSS);
  endfunction

  function automatic int unsigned active_width();
    if (width_q < 1) return 1;
    if (width_q > MAX_OUT_WIDTH_DEF) return MAX_OUT_WIDTH_DEF;
    return width_q;
  endfunction

  function automatic int unsigned active_height();
    if (height_q < 1) return 1;
    if (height_q > OUT_HEIGHT_MAX) return OUT_HEIGHT_MAX;
    return height_q;
  endfunction

  function automatic int unsigned pixels_per_frame();
    int unsigned fct;
    fct = is_downsampling() ? DOWN_FACTOR : 1;
    return active_width() * fct * active_height() * fct;
  endfunction

  function automatic void queue_result(chan_vec_t v, int unsigned col, int unsigned row,
                                       bit last);
    pixel_out_t o;
    o = {v, COL_W'(col), ROW_W'(row), last};
    expected_pixels.push_back(o);
  endfunction

  function automatic void predict_pixel(pixel_in_t px);
    chan_vec_t   v;
    chan_vec_t   res;
    int unsigned w, h, fct, in_w, in_h, x, y, cp, rp, acc;
    v   = px;
    res = '0;
    w   = active_width();
    h   = active_height();
    fct = is_downsampling() ? DOWN_FACTOR : 1;
    in_w = w * fct;
    in_h = h * fct;
    x  = col_pos / DOWN_FACTOR;
    y  = row_pos / DOWN_FACTOR;
    cp = col_pos % DOWN_FACTOR;
    rp = row_pos % DOWN_FACTOR;

    if (!is_downsampling()) begin
      queue_result(v, col_pos, row_pos, (col_pos + 1 >= in_w) && (row_pos + 1 >= in_h));
    end else if (mode_q == MODE_POINT) begin
      if (cp == 1 && rp == 1 && x < w && y < h)
        queue_result(v, x, y, (x + 1 == w) && (y + 1 == h));
    end else begin
      // horizontal pass, left neighbor of column 0 folded into column 0
      for (int k = 0; k < NCH; k++) begin
        if (cp == 2) acc = v[k];
        else if (cp == 0) acc = (col_pos == 0) ? 3 * v[k] : hsum[k] + 2 * v[k];
        else acc = hsum[k] + v[k];
        hsum[k] = SUM_W'(acc);
      end
      // vertical pass in the line store, row 0 likewise weighted by three
      if (cp == 1 && x < w && x < MAX_OUT_WIDTH_DEF) begin
        for (int k = 0; k < NCH; k++) begin
          if (rp == 2) begin
            vsum[x][k] = hsum[k];
          end else if (rp == 0) begin
            acc = (row_pos == 0) ? 3 * hsum[k] : vsum[x][k] + 2 * hsum[k];
            vsum[x][k] = SUM_W'(acc);
          end else begin
            acc = (vsum[x][k] + hsum[k] + ROUND_BIAS) >> KERNEL_SHIFT;
            res[k] = CHANNEL_BITS'(acc);
          end
        end
        if (rp == 1 && y < h)
          queue_result(res, x, y, (x + 1 == w) && (y + 1 == h));
      end
    end

    if (col_pos + 1 >= in_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= in_h) ? 0 : (row_pos + 1) & 32'h3FFF;
    end else begin
      col_pos = (col_pos + 1) & 32'hFFF;
    end
  endfunction

  function automatic pixel_in_t random_pixel();
    chan_vec_t v;
    for (int k = 0; k < NCH; k++)
      case ($urandom_range(0, 7))
        0: v[k] = '0;
        1: v[k] = '1;
        default: v[k] = CHANNEL_BITS'($urandom);
      endcase
    return pixel_in_t'(v);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_pixel(pixel_out_t got);
    pixel_out_t want;
    if (expected_pixels.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: transaction with nothing expected, col %0d row %0d",
                 $time, got.out_col, got.out_row);
      return;
    end
    want = expected_pixels.pop_front();
    check_field("out_red",      want.out_red,      got.out_red);
    check_field("out_green",    want.out_green,    got.out_green);
    check_field("out_blue",     want.out_blue,     got.out_blue);
    check_field("out_normal_x", want.out_normal_x, got.out_normal_x);
    check_field("out_normal_y", want.out_normal_y, got.out_normal_y);
    check_field("out_normal_z", want.out_normal_z, got.out_normal_z);
    check_field("out_depth",    want.out_depth,    got.out_depth);
    check_field("out_col",      16'(want.out_col), 16'(got.out_col));
    check_field("out_row",      16'(want.out_row), 16'(got.out_row));
    check_field("frame_end",    16'(want.frame_end), 16'(got.frame_end));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      check_pixel(out_data);
  end

  // result side: random stalls, plus one long hold when a test asks for it
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_pixel(pixel_in_t px);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(px);
    sent_count++;
  endtask

  task automatic send_frames(int unsigned frames);
    repeat (frames * pixels_per_frame()) send_pixel(random_pixel());
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FILTER_MODE: mode_q   = val[MODE_W-1:0];
      CFG_OUT_WIDTH:   width_q  = val[OUT_WIDTH_W-1:0];
      CFG_OUT_HEIGHT:  height_q = val[OUT_HEIGHT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // registers rewritten with the counters mid-frame (no Gaussian mode, so no
  // line store read can hit an entry of another frame), then run to frame start
  task automatic shuffle_config_midframe(int rounds);
    logic [MODE_W-1:0] pick;
    repeat (rounds) begin
      case ($urandom_range(0, 2))
        0: pick = MODE_PASS;
        1: pick = MODE_POINT;
        default: pick = MODE_ALIAS;
      endcase
      write_config(CFG_FILTER_MODE, CFG_DATA_W'(pick));
      write_config(CFG_OUT_WIDTH, CFG_DATA_W'($urandom_range(0, 7)));
      write_config(CFG_OUT_HEIGHT, CFG_DATA_W'($urandom_range(0, 5)));
      repeat ($urandom_range(1, 10)) send_pixel(random_pixel());
      wait_for_idle();
    end
    while (col_pos != 0 || row_pos != 0) send_pixel(random_pixel());
    wait_for_idle();
  endtask

  task automatic test_reset_defaults();
    repeat (5) send_pixel(random_pixel());
    wait_for_idle();
  endtask

  task automatic test_midframe_changes();
    write_config(CFG_SPARE_INDEX, '1);
    shuffle_config_midframe(6);
  endtask

  task automatic test_single_frames();
    pixel_in_t all_ones;
    pixel_in_t all_zero;
    all_ones = '1;
    all_zero = '0;
    write_config(CFG_FILTER_MODE, CFG_DATA_W'(MODE_PASS));
    write_config(CFG_OUT_WIDTH, 13'd1);
    write_config(CFG_OUT_HEIGHT, 13'd1);
    send_pixel(all_ones);
    wait_for_idle();
    // mode 3 acts as pass-through; zero sizes clamp to one
    write_config(CFG_FILTER_MODE, CFG_DATA_W'(MODE_ALIAS));
    write_config(CFG_OUT_WIDTH, 13'd0);
    write_config(CFG_OUT_HEIGHT, 13'd0);
    send_pixel(all_zero);
    wait_for_idle();
    write_config(CFG_FILTER_MODE, CFG_DATA_W'(MODE_POINT));
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? all_zero : all_ones);
    wait_for_idle();
    write_config(CFG_FILTER_MODE, CFG_DATA_W'(MODE_GAUSS));
    repeat (9) send_pixel(all_ones);
    send_frames(1);
    wait_for_idle();
  endtask

  // oversized registers on a partial row and column, then a small size written
  // mid-frame wraps the counters back to frame start
  task automatic test_size_extremes();
    write_config(CFG_FILTER_MODE, CFG_DATA_W'(MODE_PASS));
    write_config(CFG_OUT_WIDTH, 13'h7FF);
    write_config(CFG_OUT_HEIGHT, 13'd1);
    repeat (40) send_pixel(random_pixel());
    wait_for_idle();
    write_config(CFG_OUT_WIDTH, 13'd1);
    write_config(CFG_OUT_HEIGHT, 13'h1FFF);
    repeat (40) send_pixel(random_pixel());
    wait_for_idle();
    write_config(CFG_OUT_HEIGHT, 13'd1);
    send_pixel(random_pixel());
    wait_for_idle();
    write_config(CFG_FILTER_MODE, CFG_DATA_W'(MODE_GAUSS));
    write_config(CFG_OUT_WIDTH, 13'd12);
    write_config(CFG_OUT_HEIGHT, 13'd1);
    send_frames(1);
    wait_for_idle();
  endtask

  task automatic test_output_backpressure();
    write_config(CFG_FILTER_MODE, CFG_DATA_W'(MODE_PASS));
    write_config(CFG_OUT_WIDTH, 13'd4);
    write_config(CFG_OUT_HEIGHT, 13'd4);
    in_burst = 1'b1;
    hold_request = HOLD_CYCLES;
    send_frames(4);
    in_burst = 1'b0;
    wait_for_idle();
  endtask

  task automatic test_random_frames();
    int unsigned           first;
    int unsigned           frame_len;
    logic [MODE_W-1:0]     pick;
    logic [CFG_DATA_W-1:0] val;
    first = sent_count;
    while (sent_count - first < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:    pick = MODE_PASS;
        2:       pick = MODE_ALIAS;
        3, 4, 5: pick = MODE_POINT;
        default: pick = MODE_GAUSS;
      endcase
      // unused upper bits of the mode and width writes carry noise
      val = CFG_DATA_W'($urandom);
      val[MODE_W-1:0] = pick;
      write_config(CFG_FILTER_MODE, val);
      val = CFG_DATA_W'($urandom);
      val[OUT_WIDTH_W-1:0] = ($urandom_range(0, 9) == 0) ? '0 :
                             OUT_WIDTH_W'($urandom_range(1, 6));
      write_config(CFG_OUT_WIDTH, val);
      val = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 4));
      write_config(CFG_OUT_HEIGHT, val);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      send_frames($urandom_range(1, 2));
      if ($urandom_range(0, 4) == 0) begin
        frame_len = pixels_per_frame();
        if (frame_len > 1)
          repeat ($urandom_range(1, frame_len - 1)) send_pixel(random_pixel());
        wait_for_idle();
        shuffle_config_midframe($urandom_range(1, 3));
      end
      wait_for_idle();
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FILTER_MODE;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_midframe_changes();
    test_single_frames();
    test_size_extremes();
    test_output_backpressure();
    test_random_frames();

    wait_for_idle();
    repeat (2 * IDLE_TAIL) @(posedge clk);
    if (mismatch_count == 0)
      $display("gaussian_downsample_by_three_core verification clean");
    else
      $display("gaussian_downsample_by_three_core verification failed");
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("gaussian_downsample_by_three_core verification failed");
    $finish;
  end

endmodule
